// ===== sv/epp_pkg.sv =====
// Package: shared widths, pixel codes, overlay constants and register indexes.
package epp_pkg;

    localparam int BYTE_W = 8;
    localparam int COL_W  = 10;
    localparam int CFG_INDEX_W = 3;

    localparam logic [COL_W-1:0] COL_MAX = 10'd1023;

    localparam logic [1:0] PIX_WHITE  = 2'h0;
    localparam logic [1:0] PIX_BLACK  = 2'h1;
    localparam logic [1:0] PIX_RED    = 2'h2;
    localparam logic [1:0] PIX_YELLOW = 2'h3;

    localparam logic signed [7:0] DISC_CX = 8'sd5;
    localparam logic signed [7:0] DISC_CY = 8'sd5;
    localparam logic signed [7:0] DISC_R2 = 8'sd25;
    localparam logic signed [7:0] DISC_INNER_R2 = 8'sd4;
    localparam logic [COL_W-1:0] DISC_COL_LAST = 10'd10;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_GROUPS    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TWO_PLANES    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERT_BLACK  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERT_SECOND = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFLINE_MARK  = 3'd4;

    localparam logic [BYTE_W-1:0] ROW_GROUPS_RESET = 8'd28;

endpackage

// ===== sv/epp_plane_if.sv =====
// Interface: input channel carrying one plane byte pair per beat.
interface epp_plane_if;
    logic                        valid;
    logic                        ready;
    logic [epp_pkg::BYTE_W-1:0]  black_byte;
    logic [epp_pkg::BYTE_W-1:0]  second_byte;
    logic                        first_of_frame;

    modport source (output valid, output black_byte, output second_byte,
                    output first_of_frame, input ready);
    modport sink   (input valid, input black_byte, input second_byte,
                    input first_of_frame, output ready);
endinterface

// ===== sv/epp_pixel_if.sv =====
// Interface: output channel carrying two packed pixel bytes per beat.
interface epp_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [epp_pkg::BYTE_W-1:0]  high_pixels;
    logic [epp_pkg::BYTE_W-1:0]  low_pixels;

    modport source (output valid, output high_pixels, output low_pixels, input ready);
    modport sink   (input valid, input high_pixels, input low_pixels, output ready);
endinterface

// ===== sv/epaper_plane_to_pixel_packer.sv =====
// Top level: plane byte pair to packed 2-bit pixel codes with offline disc overlay.
// Datapath: an input register, then a result register, between input beat and output beat.
// Throughput: one beat per cycle; the two register stages stall together on output
// backpressure and the input is taken whenever the first stage can move forward.
// Reset: clears stage valid bits and the column and row-group counters, and loads
// the configuration registers with their reset values.
module epaper_plane_to_pixel_packer #(
    parameter int MAX_ROW_GROUPS = 128
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [epp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [epp_pkg::BYTE_W-1:0]        cfg_data,
    epp_plane_if.sink                         in_ch,
    epp_pixel_if.source                       out_ch
);

    localparam int EFF_MAX = (MAX_ROW_GROUPS > 255) ? 255 : MAX_ROW_GROUPS;
    localparam int RG_W    = (EFF_MAX > 1) ? $clog2(EFF_MAX) : 1;
    localparam logic [epp_pkg::BYTE_W-1:0] EFF_MAX_B = epp_pkg::BYTE_W'(EFF_MAX);

    logic [epp_pkg::BYTE_W-1:0] row_groups_reg;
    logic                       two_planes_reg;
    logic                       invert_black_reg;
    logic                       invert_second_reg;
    logic                       offline_mark_reg;

    logic [epp_pkg::COL_W-1:0]  col_reg, col_next;
    logic [RG_W-1:0]            rg_reg, rg_next;

    logic                       s1_valid_reg;
    logic [epp_pkg::BYTE_W-1:0] s1_black_reg;
    logic [epp_pkg::BYTE_W-1:0] s1_second_reg;
    logic [epp_pkg::COL_W-1:0]  s1_col_reg;
    logic [RG_W-1:0]            s1_rg_reg;

    logic                       out_valid_reg;
    logic [epp_pkg::BYTE_W-1:0] high_reg, high_next;
    logic [epp_pkg::BYTE_W-1:0] low_reg, low_next;

    logic                       s2_load;
    logic                       s1_load;
    logic                       in_fire;
    logic [epp_pkg::COL_W-1:0]  col_base;
    logic [RG_W-1:0]            rg_base;
    logic [epp_pkg::BYTE_W-1:0] eff_groups;

    assign s2_load = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign s1_load = !s1_valid_reg || s2_load;
    assign in_ch.ready = s1_load;
    assign in_fire = in_ch.valid && s1_load;

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.high_pixels = high_reg;
    assign out_ch.low_pixels  = low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_groups_reg    <= epp_pkg::ROW_GROUPS_RESET;
            two_planes_reg    <= 1'b0;
            invert_black_reg  <= 1'b1;
            invert_second_reg <= 1'b0;
            offline_mark_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                epp_pkg::CFG_ROW_GROUPS:    row_groups_reg    <= cfg_data;
                epp_pkg::CFG_TWO_PLANES:    two_planes_reg    <= cfg_data[0];
                epp_pkg::CFG_INVERT_BLACK:  invert_black_reg  <= cfg_data[0];
                epp_pkg::CFG_INVERT_SECOND: invert_second_reg <= cfg_data[0];
                epp_pkg::CFG_OFFLINE_MARK:  offline_mark_reg  <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        if (row_groups_reg == '0)
            eff_groups = 8'd1;
        else if (row_groups_reg > EFF_MAX_B)
            eff_groups = EFF_MAX_B;
        else
            eff_groups = row_groups_reg;

        col_base = in_ch.first_of_frame ? '0 : col_reg;
        rg_base  = in_ch.first_of_frame ? '0 : rg_reg;

        if ((9'(rg_base) + 9'd1) >= {1'b0, eff_groups})
        begin
            rg_next  = '0;
            col_next = (col_base < epp_pkg::COL_MAX) ? col_base + 1'b1 : col_base;
        end
        else
        begin
            rg_next  = rg_base + 1'b1;
            col_next = col_base;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            rg_reg       <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                col_reg <= col_next;
                rg_reg  <= rg_next;
            end
            if (s1_load)
                s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_black_reg  <= in_ch.black_byte;
            s1_second_reg <= two_planes_reg ? in_ch.second_byte : '0;
            s1_col_reg    <= col_base;
            s1_rg_reg     <= rg_base;
        end
    end

    always_comb
    begin
        logic [epp_pkg::BYTE_W-1:0] bw;
        logic [epp_pkg::BYTE_W-1:0] sc;
        logic signed [7:0]          dx;
        logic signed [7:0]          dy;
        logic signed [7:0]          d2;
        logic [3:0]                 row;
        logic                       near;
        logic [1:0]                 px;

        bw = s1_black_reg;
        sc = s1_second_reg;
        near = (s1_col_reg <= epp_pkg::DISC_COL_LAST) && (s1_rg_reg <= RG_W'(1));
        dx = $signed({4'b0000, s1_col_reg[3:0]}) - epp_pkg::DISC_CX;
        high_next = '0;
        low_next  = '0;

        for (int i = 0; i < 8; i++)
        begin
            row = {s1_rg_reg[0], 3'(7 - i)};
            dy = $signed({4'b0000, row}) - epp_pkg::DISC_CY;
            d2 = dx * dx + dy * dy;
            if (offline_mark_reg && near && (d2 <= epp_pkg::DISC_R2))
            begin
                bw[i] = 1'b0;
                sc[i] = (d2 > epp_pkg::DISC_INNER_R2);
            end
        end

        if (invert_black_reg)
            bw = ~bw;
        if (two_planes_reg && invert_second_reg)
            sc = ~sc;

        for (int i = 0; i < 8; i++)
        begin
            if (sc[i])
                px = bw[i] ? epp_pkg::PIX_YELLOW : epp_pkg::PIX_RED;
            else
                px = bw[i] ? epp_pkg::PIX_BLACK : epp_pkg::PIX_WHITE;
            if (i >= 4)
                high_next[(i - 4) * 2 +: 2] = px;
            else
                low_next[i * 2 +: 2] = px;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || out_ch.ready)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            high_reg <= high_next;
            low_reg  <= low_next;
        end
    end

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_ch.first_of_frame |=> s1_col_reg == '0 && s1_rg_reg == '0)
        else $error("frame start did not restart the byte position");

    a_col_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg == epp_pkg::COL_MAX && !(in_fire && in_ch.first_of_frame)
        |=> col_reg == epp_pkg::COL_MAX)
        else $error("column counter left saturation");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s2_load |=> s1_valid_reg)
        else $error("stalled beat dropped from input stage");

    a_counters_move: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(col_reg) && $stable(rg_reg))
        else $error("position counters moved without an input beat");

endmodule
